// ===== rtl/mcm_pkg.sv =====
// Shared types and constants for the 4x4 column matrix multiply core.
package mcm_pkg;

    localparam int ELEM_W       = 32;
    localparam int PROD_W       = 2 * ELEM_W;
    localparam int FIELD_ROWS   = 4;
    localparam int COL_W        = 2;
    localparam int DIM_DEFAULT  = 4;
    localparam int FRAC_DEFAULT = 16;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [COL_W-1:0]         col_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } op_t;

    localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
    localparam elem_t ELEM_MIN = 32'sh8000_0000;

    // Control that travels alongside each word in the pipeline.
    typedef struct packed
    {
        logic valid;
        col_t column;
    } tag_t;

endpackage

// ===== rtl/mcm_left_store.sv =====
// Left matrix storage: one column written per load word, all entries read in parallel.
module mcm_left_store #(
    parameter int NU = mcm_pkg::DIM_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mcm_pkg::col_t wr_col,
    input  mcm_pkg::elem_t wr_data [NU],
    output mcm_pkg::elem_t mat     [NU][NU]
);

    mcm_pkg::elem_t mat_reg [NU][NU];

    for (genvar c = 0; c < NU; c++)
    begin : g_col
        for (genvar r = 0; r < NU; r++)
        begin : g_row
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mat_reg[r][c] <= '0;
                end
                else if (wr_en && (wr_col == mcm_pkg::COL_W'(c)))
                begin
                    mat_reg[r][c] <= wr_data[r];
                end
            end

            assign mat[r][c] = mat_reg[r][c];
        end
    end

endmodule

// ===== rtl/mcm_mul_array.sv =====
// Multiply stage: every left-matrix entry times the matching right-column element.
module mcm_mul_array #(
    parameter int NU = mcm_pkg::DIM_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  mcm_pkg::tag_t  tag_in,
    input  mcm_pkg::elem_t mat  [NU][NU],
    input  mcm_pkg::elem_t rhs  [NU],
    output logic           ready,
    output mcm_pkg::tag_t  tag_out,
    output mcm_pkg::prod_t prod [NU][NU]
);

    mcm_pkg::tag_t  tag_reg;
    mcm_pkg::prod_t prod_reg  [NU][NU];
    mcm_pkg::prod_t prod_next [NU][NU];

    assign ready = !tag_reg.valid || take;

    always_comb
    begin
        for (int r = 0; r < NU; r++)
        begin
            for (int i = 0; i < NU; i++)
            begin
                prod_next[r][i] = mcm_pkg::PROD_W'(mat[r][i]) * mcm_pkg::PROD_W'(rhs[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (ready)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign tag_out = tag_reg;
    assign prod    = prod_reg;

endmodule

// ===== rtl/mcm_reduce.sv =====
// Reduction stages: pairwise sums, final sum, fixed-point shift and saturation.
module mcm_reduce #(
    parameter int NU        = mcm_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mcm_pkg::FRAC_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mcm_pkg::tag_t  tag_in,
    input  mcm_pkg::prod_t prod [NU][NU],
    input  logic           out_stall,
    output logic           ready,
    output mcm_pkg::tag_t  tag_out,
    output mcm_pkg::elem_t res  [mcm_pkg::FIELD_ROWS],
    output logic           overflow
);

    localparam int NH     = (NU + 1) / 2;
    localparam int HALF_W = mcm_pkg::PROD_W + 1;
    localparam int SUM_W  = mcm_pkg::PROD_W + 2;

    mcm_pkg::tag_t          tag3_reg;
    mcm_pkg::tag_t          tag4_reg;
    logic signed [HALF_W-1:0] half_reg  [NU][NH];
    logic signed [HALF_W-1:0] half_next [NU][NH];
    mcm_pkg::elem_t         res_reg   [mcm_pkg::FIELD_ROWS];
    mcm_pkg::elem_t         res_next  [mcm_pkg::FIELD_ROWS];
    logic [mcm_pkg::FIELD_ROWS-1:0] row_sat;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic                   ready4;

    assign ready4 = !tag4_reg.valid || !out_stall;
    assign ready  = !tag3_reg.valid || ready4;

    // Pairwise sums; an odd last term passes through alone.
    for (genvar r = 0; r < NU; r++)
    begin : g_half_row
        for (genvar k = 0; k < NH; k++)
        begin : g_half
            if (2 * k + 1 < NU)
            begin : g_pair
                assign half_next[r][k] = HALF_W'(prod[r][2*k]) + HALF_W'(prod[r][2*k+1]);
            end
            else
            begin : g_single
                assign half_next[r][k] = HALF_W'(prod[r][2*k]);
            end
        end
    end

    for (genvar r = 0; r < mcm_pkg::FIELD_ROWS; r++)
    begin : g_out_row
        if (r < NU)
        begin : g_live
            logic signed [SUM_W-1:0] total;
            logic signed [SUM_W-1:0] shifted;
            logic                    fits;

            always_comb
            begin
                total = '0;
                for (int k = 0; k < NH; k++)
                begin
                    total = total + SUM_W'(half_reg[r][k]);
                end
                shifted = total >>> FRAC_BITS;
                // fits when every bit above the sign of a 32-bit word matches it
                fits = (&shifted[SUM_W-1:mcm_pkg::ELEM_W-1])
                    || !(|shifted[SUM_W-1:mcm_pkg::ELEM_W-1]);
                if (fits)
                begin
                    res_next[r] = shifted[mcm_pkg::ELEM_W-1:0];
                end
                else if (shifted[SUM_W-1])
                begin
                    res_next[r] = mcm_pkg::ELEM_MIN;
                end
                else
                begin
                    res_next[r] = mcm_pkg::ELEM_MAX;
                end
                row_sat[r] = !fits;
            end
        end
        else
        begin : g_dead
            assign res_next[r] = '0;
            assign row_sat[r]  = 1'b0;
        end
    end

    assign overflow_next = |row_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            if (ready)
            begin
                tag3_reg <= tag_in;
            end
            if (ready4)
            begin
                tag4_reg <= tag3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            half_reg <= half_next;
        end
        if (ready4)
        begin
            res_reg      <= res_next;
            overflow_reg <= overflow_next;
        end
    end

    assign tag_out  = tag4_reg;
    assign res      = res_reg;
    assign overflow = overflow_reg;

endmodule

// ===== rtl/matrix4_column_multiply_core.sv =====
// Top level: 4x4 Q16.16 matrix times streamed column, pipelined four deep.
// A word is accepted every cycle while out_stall is low. A multiply word raises
// out_valid with its result column once it has passed the registers in order
// (input register, multiplier array of sixteen 32x32 products, pairwise adds,
// final add with shift and saturation); load words give no result and update
// the left matrix in order, so every multiply word behind a load sees the new
// column. The left matrix resets to zero. Throughput is one column per cycle
// while out_stall is low, set by the fully parallel multiplier array;
// back-pressure from out_stall ripples to in_stall in the same cycle only
// through stages that are holding a word.
module matrix4_column_multiply_core #(
    parameter int DIM       = mcm_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mcm_pkg::FRAC_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           op,
    input  mcm_pkg::col_t  column,
    input  mcm_pkg::elem_t elem0,
    input  mcm_pkg::elem_t elem1,
    input  mcm_pkg::elem_t elem2,
    input  mcm_pkg::elem_t elem3,
    output logic           out_valid,
    input  logic           out_stall,
    output mcm_pkg::col_t  out_column,
    output mcm_pkg::elem_t res0,
    output mcm_pkg::elem_t res1,
    output mcm_pkg::elem_t res2,
    output mcm_pkg::elem_t res3,
    output logic           overflow
);

    // Only the top-left block up to four wide ever contributes.
    localparam int NU = (DIM < mcm_pkg::FIELD_ROWS) ? DIM : mcm_pkg::FIELD_ROWS;

    mcm_pkg::elem_t in_elem [mcm_pkg::FIELD_ROWS];

    logic           s1_valid_reg;
    logic           s1_op_reg;
    mcm_pkg::col_t  s1_col_reg;
    mcm_pkg::elem_t s1_elem_reg [NU];
    logic           ready1;
    logic           ready2;
    logic           ready3;
    logic           wr_en;
    mcm_pkg::tag_t  s1_tag;
    mcm_pkg::tag_t  s2_tag;
    mcm_pkg::tag_t  s4_tag;
    mcm_pkg::elem_t mat  [NU][NU];
    mcm_pkg::prod_t prod [NU][NU];
    mcm_pkg::elem_t res  [mcm_pkg::FIELD_ROWS];

    assign in_elem[0] = elem0;
    assign in_elem[1] = elem1;
    assign in_elem[2] = elem2;
    assign in_elem[3] = elem3;

    assign ready1   = !s1_valid_reg || ready2;
    assign in_stall = !ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ready1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_op_reg  <= op;
            s1_col_reg <= column;
            for (int i = 0; i < NU; i++)
            begin
                s1_elem_reg[i] <= in_elem[i];
            end
        end
    end

    // Loads commit as they leave the first stage, in order with multiplies.
    assign wr_en = s1_valid_reg && ready2 && (s1_op_reg == mcm_pkg::OP_LOAD);

    assign s1_tag.valid  = s1_valid_reg && (s1_op_reg == mcm_pkg::OP_MUL);
    assign s1_tag.column = s1_col_reg;

    mcm_left_store #(
        .NU (NU)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_col  (s1_col_reg),
        .wr_data (s1_elem_reg),
        .mat     (mat)
    );

    mcm_mul_array #(
        .NU (NU)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (ready3),
        .tag_in  (s1_tag),
        .mat     (mat),
        .rhs     (s1_elem_reg),
        .ready   (ready2),
        .tag_out (s2_tag),
        .prod    (prod)
    );

    mcm_reduce #(
        .NU        (NU),
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (s2_tag),
        .prod      (prod),
        .out_stall (out_stall),
        .ready     (ready3),
        .tag_out   (s4_tag),
        .res       (res),
        .overflow  (overflow)
    );

    assign out_valid  = s4_tag.valid;
    assign out_column = s4_tag.column;
    assign res0       = res[0];
    assign res1       = res[1];
    assign res2       = res[2];
    assign res3       = res[3];

`ifndef SYNTHESIS
    a_empty_front_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty front stage");

    a_free_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    a_load_makes_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !s2_tag.valid)
        else $error("load word entered the multiply stage");

    a_overflow_clips: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
            ((res0 == mcm_pkg::ELEM_MAX) || (res0 == mcm_pkg::ELEM_MIN)
            || (res1 == mcm_pkg::ELEM_MAX) || (res1 == mcm_pkg::ELEM_MIN)
            || (res2 == mcm_pkg::ELEM_MAX) || (res2 == mcm_pkg::ELEM_MIN)
            || (res3 == mcm_pkg::ELEM_MAX) || (res3 == mcm_pkg::ELEM_MIN)))
        else $error("overflow flagged without a clipped result");
`endif

endmodule
